/* rtl/core/obdps_pkg.sv */
// ----------------------------------------------------------------------------
// OBD poll scheduler package
// Shared types, codes and constants of the poll scheduler and its sequencer.
// ----------------------------------------------------------------------------
package obdps_pkg;

   // Micro-program counter.
   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   // Event opcodes.
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_RESP   = 2'd2;
   localparam logic [1:0] OP_BITMAP = 2'd3;

   // Scheduler phases, as reported on the result.
   localparam logic [1:0] PH_INIT  = 2'd0;
   localparam logic [1:0] PH_QUERY = 2'd1;
   localparam logic [1:0] PH_IDLE  = 2'd2;
   localparam logic [1:0] PH_WAIT  = 2'd3;

   // What a result sends.
   localparam logic [1:0] SEND_NONE = 2'd0;
   localparam logic [1:0] SEND_INIT = 2'd1;
   localparam logic [1:0] SEND_PID  = 2'd2;

   // PIDs.
   localparam logic [7:0] PID_SUPPORT = 8'h00;
   localparam logic [7:0] PID_LOAD    = 8'h05;
   localparam logic [7:0] PID_RPM     = 8'h0C;
   localparam logic [7:0] PID_SPEED   = 8'h0D;
   localparam logic [7:0] PID_INTAKE  = 8'h0F;

   // Bit 31 of the bitmap is PID 01, so PID 0D sits at bit 19.
   localparam int SPEED_SUPPORT_BIT = 19;

   // Number of adapter init commands.
   localparam logic [2:0] INIT_CMD_COUNT = 3'd4;

   // Configuration registers.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIMEOUT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_TIMEOUT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_ALLOWED = 2'd3;

   localparam logic [15:0] STEP_TIMEOUT_RST  = 16'd300;
   localparam logic [15:0] POLL_INTERVAL_RST = 16'd80;
   localparam logic [15:0] WAIT_TIMEOUT_RST  = 16'd250;

   // Position inside one schedule round while the schedule is built.
   localparam logic [1:0] SUB_FAST0 = 2'd0;
   localparam logic [1:0] SUB_FAST1 = 2'd1;
   localparam logic [1:0] SUB_SLOW  = 2'd2;

   // Micro-operations of the datapath.
   typedef enum logic [3:0] {
      UOP_NOP        = 4'd0,
      UOP_START      = 4'd1,
      UOP_BUILD_INIT = 4'd2,
      UOP_BUILD_STEP = 4'd3,
      UOP_FINISH     = 4'd4,
      UOP_ELAPSED    = 4'd5,
      UOP_TICK_INIT  = 4'd6,
      UOP_TICK_QUERY = 4'd7,
      UOP_READ_SLOT  = 4'd8,
      UOP_TICK_WAIT  = 4'd9,
      UOP_TICK_IDLE  = 4'd10,
      UOP_RESP       = 4'd11,
      UOP_BITMAP     = 4'd12
   } uop_type;

   // Next-address selection.
   typedef enum logic [2:0] {
      COND_ALWAYS     = 3'd0,
      COND_BUILD_MORE = 3'd1,
      COND_REBUILD    = 3'd2,
      COND_NEW_MAP    = 3'd3,
      COND_DISPATCH   = 3'd4
   } cond_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      upc_type  target_t;
      upc_type  target_f;
   } ctrl_word_type;

   // Micro-program addresses.
   localparam upc_type UA_START      = 4'd0;
   localparam upc_type UA_BUILD_INIT = 4'd1;
   localparam upc_type UA_BUILD_STEP = 4'd2;
   localparam upc_type UA_FINISH     = 4'd3;
   localparam upc_type UA_TICK       = 4'd4;
   localparam upc_type UA_TICK_PHASE = 4'd5;
   localparam upc_type UA_TICK_QUERY = 4'd6;
   localparam upc_type UA_READ_SLOT  = 4'd7;
   localparam upc_type UA_TICK_WAIT  = 4'd8;
   localparam upc_type UA_TICK_IDLE  = 4'd9;
   localparam upc_type UA_RESP       = 4'd10;
   localparam upc_type UA_BITMAP     = 4'd11;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic       build_more;
      logic       rebuild;
      logic       new_map;
      logic [1:0] phase;
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [7:0]  resp_pid;
      logic [31:0] support_mask;
   } req_type;

   typedef struct packed {
      logic [1:0] send_kind;
      logic [1:0] init_cmd_index;
      logic [7:0] req_pid;
      logic       claimed;
      logic [1:0] phase_now;
      logic       speed_polled;
   } rsp_type;

endpackage

/* rtl/core/obd_poll_scheduler_top.sv */
// ----------------------------------------------------------------------------
// OBD poll scheduler
// Request sequencer for a vehicle diagnostic adapter: init commands, support
// query and a round-robin PID poll schedule.
//
// Items arrive on the req_ channel (valid/stall): start, millisecond tick,
// parsed PID response or supported-PID bitmap. Every item yields exactly one
// result item on the rsp_ channel, telling what to send (nothing, an init
// command or a mode 01 PID request), whether a response ended the wait, the
// phase after the item and whether speed is in the schedule.
// Items are handled one at a time by a micro-programmed sequencer. A start, a
// first bitmap or a bitmap timeout also rebuilds the schedule; the rebuild
// visits one place of the schedule per cycle.
// The result sits in an output register; the next item is taken while it
// waits. When the receiver stalls, the sequencer holds at its last step and
// req_stall stays high until the result register frees up.
// Reset is synchronous and needs no clearing pass; configuration returns to
// 300/80/250 ms with speed allowed. Write csr_ registers only while idle.
// ----------------------------------------------------------------------------
module obd_poll_scheduler_top #(
   parameter int SLOW_EVERY_N_TURNS = 4,
   parameter int SCHEDULE_MAX       = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  obdps_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output obdps_pkg::rsp_type               rsp_data,
   input  logic                             csr_wr_en,
   input  logic [obdps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [obdps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import obdps_pkg::*;

   upc_type       upc;
   ctrl_word_type cw;
   status_type    status;
   rsp_type       result;
   logic          accept;
   logic          exec;

   obdps_ucode_rom u_rom (
      .upc_addr (upc),
      .cw       (cw)
   );

   obdps_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cw        (cw),
      .status    (status),
      .result    (result),
      .upc       (upc),
      .accept    (accept),
      .exec      (exec)
   );

   obdps_datapath #(
      .SLOW_EVERY_N_TURNS (SLOW_EVERY_N_TURNS),
      .SCHEDULE_MAX       (SCHEDULE_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_data),
      .exec      (exec),
      .cw        (cw),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .result    (result)
   );

endmodule

/* rtl/core/obdps_ucode_rom.sv */
// ----------------------------------------------------------------------------
// OBD poll scheduler micro-program store
// Read-only table of control words, one per micro-program address.
// ----------------------------------------------------------------------------
module obdps_ucode_rom (
   input  obdps_pkg::upc_type       upc_addr,
   output obdps_pkg::ctrl_word_type cw
);
   import obdps_pkg::*;

   always_comb begin
      case (upc_addr)
         UA_START:      cw = '{UOP_START,      COND_ALWAYS,     UA_BUILD_INIT, UA_BUILD_INIT};
         UA_BUILD_INIT: cw = '{UOP_BUILD_INIT, COND_ALWAYS,     UA_BUILD_STEP, UA_BUILD_STEP};
         UA_BUILD_STEP: cw = '{UOP_BUILD_STEP, COND_BUILD_MORE, UA_BUILD_STEP, UA_FINISH};
         UA_FINISH:     cw = '{UOP_FINISH,     COND_ALWAYS,     UA_FINISH,     UA_FINISH};
         // The tick entry jumps to the handler of the current phase.
         UA_TICK:       cw = '{UOP_ELAPSED,    COND_DISPATCH,   UA_TICK_PHASE, UA_TICK_PHASE};
         UA_TICK_PHASE: cw = '{UOP_TICK_INIT,  COND_ALWAYS,     UA_FINISH,     UA_FINISH};
         UA_TICK_QUERY: cw = '{UOP_TICK_QUERY, COND_REBUILD,    UA_BUILD_INIT, UA_FINISH};
         UA_READ_SLOT:  cw = '{UOP_READ_SLOT,  COND_ALWAYS,     UA_TICK_IDLE,  UA_TICK_IDLE};
         UA_TICK_WAIT:  cw = '{UOP_TICK_WAIT,  COND_ALWAYS,     UA_FINISH,     UA_FINISH};
         UA_TICK_IDLE:  cw = '{UOP_TICK_IDLE,  COND_ALWAYS,     UA_FINISH,     UA_FINISH};
         UA_RESP:       cw = '{UOP_RESP,       COND_ALWAYS,     UA_FINISH,     UA_FINISH};
         UA_BITMAP:     cw = '{UOP_BITMAP,     COND_NEW_MAP,    UA_BUILD_INIT, UA_FINISH};
         default:       cw = '{UOP_NOP,        COND_ALWAYS,     UA_FINISH,     UA_FINISH};
      endcase
   end

endmodule

/* rtl/core/obdps_datapath.sv */
// ----------------------------------------------------------------------------
// OBD poll scheduler datapath
// Scheduler state, timers and schedule memory, driven by one control word
// per cycle.
// ----------------------------------------------------------------------------
module obdps_datapath #(
   parameter int SLOW_EVERY_N_TURNS = 4,
   parameter int SCHEDULE_MAX       = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    accept,
   input  obdps_pkg::req_type                      item,
   input  logic                                    exec,
   input  obdps_pkg::ctrl_word_type                cw,
   input  logic                                    csr_wr_en,
   input  logic [obdps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [obdps_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output obdps_pkg::status_type                   status,
   output obdps_pkg::rsp_type                      result
);
   import obdps_pkg::*;

   localparam int SW = $clog2(SCHEDULE_MAX);
   localparam int LW = $clog2(SCHEDULE_MAX + 1);
   localparam int RW = (SLOW_EVERY_N_TURNS > 2) ? $clog2(SLOW_EVERY_N_TURNS) : 1;
   localparam logic [RW-1:0] LAST_ROUND = RW'(SLOW_EVERY_N_TURNS - 1);

   // Configuration.
   logic [15:0] step_to_ff, step_to_in;
   logic [15:0] poll_iv_ff, poll_iv_in;
   logic [15:0] wait_to_ff, wait_to_in;
   logic        speed_ok_ff, speed_ok_in;

   // Scheduler state.
   logic [1:0]    phase_ff, phase_in;
   logic [2:0]    init_step_ff, init_step_in;
   logic          query_sent_ff, query_sent_in;
   logic          support_known_ff, support_known_in;
   logic          speed_sched_ff, speed_sched_in;
   logic [LW-1:0] sched_len_ff, sched_len_in;
   logic [SW-1:0] sched_slot_ff, sched_slot_in;
   logic [7:0]    awaited_ff, awaited_in;
   logic [31:0]   last_act_ff, last_act_in;
   logic [31:0]   last_tick_ff, last_tick_in;

   // Working registers.
   req_type       item_ff;
   logic [31:0]   elapsed_ff, elapsed_in;
   logic          build_speed_ff, build_speed_in;
   logic [RW-1:0] round_ff, round_in;
   logic [1:0]    sub_ff, sub_in;
   logic [1:0]    kind_ff, kind_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [7:0]    req_pid_ff, req_pid_in;
   logic          claimed_ff, claimed_in;

   // Schedule memory.
   logic [7:0]    sched_mem [SCHEDULE_MAX];
   logic [7:0]    rd_data_ff;
   logic          wr_en;
   logic [7:0]    wr_pid;

   logic          cand;
   logic [7:0]    cand_pid;
   logic [2:0]    step_next;
   logic [LW-1:0] slot_inc;
   logic          wait_over;

   assign wait_over = elapsed_ff >= 32'(wait_to_ff);
   assign step_next = init_step_ff + 3'd1;
   assign slot_inc  = LW'(sched_slot_ff) + LW'(1);

   // Candidate entry at the current place of the round being built.
   always_comb begin
      case (sub_ff)
         SUB_FAST0: begin
            cand     = 1'b1;
            cand_pid = PID_RPM;
         end
         SUB_FAST1: begin
            cand     = build_speed_ff;
            cand_pid = PID_SPEED;
         end
         SUB_SLOW: begin
            // Slow PIDs follow only the first two rounds.
            cand     = 32'(round_ff) < 32'd2;
            cand_pid = (round_ff == '0) ? PID_LOAD : PID_INTAKE;
         end
         default: begin
            cand     = 1'b0;
            cand_pid = PID_RPM;
         end
      endcase
   end

   assign status.build_more = !((round_ff == LAST_ROUND) && (sub_ff == SUB_SLOW));
   assign status.rebuild    = query_sent_ff && !support_known_ff && wait_over;
   assign status.new_map    = !support_known_ff;
   assign status.phase      = phase_ff;

   assign result.send_kind      = kind_ff;
   assign result.init_cmd_index = cmd_ff;
   assign result.req_pid        = req_pid_ff;
   assign result.claimed        = claimed_ff;
   assign result.phase_now      = phase_ff;
   assign result.speed_polled   = speed_sched_ff;

   always_comb begin
      step_to_in       = step_to_ff;
      poll_iv_in       = poll_iv_ff;
      wait_to_in       = wait_to_ff;
      speed_ok_in      = speed_ok_ff;
      phase_in         = phase_ff;
      init_step_in     = init_step_ff;
      query_sent_in    = query_sent_ff;
      support_known_in = support_known_ff;
      speed_sched_in   = speed_sched_ff;
      sched_len_in     = sched_len_ff;
      sched_slot_in    = sched_slot_ff;
      awaited_in       = awaited_ff;
      last_act_in      = last_act_ff;
      last_tick_in     = last_tick_ff;
      elapsed_in       = elapsed_ff;
      build_speed_in   = build_speed_ff;
      round_in         = round_ff;
      sub_in           = sub_ff;
      kind_in          = kind_ff;
      cmd_in           = cmd_ff;
      req_pid_in       = req_pid_ff;
      claimed_in       = claimed_ff;
      wr_en            = 1'b0;
      wr_pid           = cand_pid;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_STEP_TIMEOUT:  step_to_in  = csr_wdata;
            CSR_POLL_INTERVAL: poll_iv_in  = csr_wdata;
            CSR_WAIT_TIMEOUT:  wait_to_in  = csr_wdata;
            CSR_SPEED_ALLOWED: speed_ok_in = csr_wdata[0];
            default:           speed_ok_in = speed_ok_ff;
         endcase
      end

      if (accept) begin
         kind_in    = SEND_NONE;
         cmd_in     = 2'd0;
         req_pid_in = 8'd0;
         claimed_in = 1'b0;
      end

      if (exec) begin
         case (cw.uop)
            UOP_START: begin
               phase_in         = PH_INIT;
               init_step_in     = 3'd0;
               query_sent_in    = 1'b0;
               support_known_in = 1'b0;
               build_speed_in   = 1'b0;
               kind_in          = SEND_INIT;
               cmd_in           = 2'd0;
               last_act_in      = item_ff.now_ms;
            end
            UOP_BUILD_INIT: begin
               sched_len_in   = '0;
               sched_slot_in  = '0;
               speed_sched_in = 1'b0;
               round_in       = '0;
               sub_in         = SUB_FAST0;
            end
            UOP_BUILD_STEP: begin
               if (cand && (sched_len_ff < LW'(SCHEDULE_MAX))) begin
                  wr_en        = 1'b1;
                  sched_len_in = sched_len_ff + LW'(1);
                  if (cand_pid == PID_SPEED) begin
                     speed_sched_in = 1'b1;
                  end
               end
               if (sub_ff == SUB_SLOW) begin
                  sub_in   = SUB_FAST0;
                  round_in = round_ff + RW'(1);
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
            UOP_ELAPSED: begin
               elapsed_in   = item_ff.now_ms - last_act_ff;
               last_tick_in = item_ff.now_ms;
            end
            UOP_TICK_INIT: begin
               if (elapsed_ff >= 32'(step_to_ff)) begin
                  init_step_in = step_next;
                  if (step_next < INIT_CMD_COUNT) begin
                     kind_in     = SEND_INIT;
                     cmd_in      = step_next[1:0];
                     last_act_in = item_ff.now_ms;
                  end else begin
                     phase_in      = PH_QUERY;
                     query_sent_in = 1'b0;
                  end
               end
            end
            UOP_TICK_QUERY: begin
               if (!query_sent_ff) begin
                  kind_in       = SEND_PID;
                  req_pid_in    = PID_SUPPORT;
                  query_sent_in = 1'b1;
                  last_act_in   = item_ff.now_ms;
               end else if (support_known_ff || wait_over) begin
                  // On a bitmap timeout the schedule is rebuilt without speed.
                  build_speed_in = 1'b0;
                  phase_in       = PH_IDLE;
                  last_act_in    = item_ff.now_ms;
               end
            end
            UOP_TICK_IDLE: begin
               if (elapsed_ff >= 32'(poll_iv_ff)) begin
                  awaited_in = rd_data_ff;
                  kind_in    = SEND_PID;
                  req_pid_in = rd_data_ff;
                  if ((sched_len_ff == '0) || (slot_inc >= sched_len_ff)) begin
                     sched_slot_in = '0;
                  end else begin
                     sched_slot_in = slot_inc[SW-1:0];
                  end
                  phase_in    = PH_WAIT;
                  last_act_in = item_ff.now_ms;
               end
            end
            UOP_TICK_WAIT: begin
               if (wait_over) begin
                  phase_in    = PH_IDLE;
                  last_act_in = item_ff.now_ms;
               end
            end
            UOP_RESP: begin
               if ((phase_ff == PH_WAIT) && (item_ff.resp_pid == awaited_ff)) begin
                  phase_in    = PH_IDLE;
                  last_act_in = last_tick_ff;
                  claimed_in  = 1'b1;
               end
            end
            UOP_BITMAP: begin
               if (!support_known_ff) begin
                  support_known_in = 1'b1;
                  build_speed_in   = item_ff.support_mask[SPEED_SUPPORT_BIT] && speed_ok_ff;
               end
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_to_ff       <= STEP_TIMEOUT_RST;
         poll_iv_ff       <= POLL_INTERVAL_RST;
         wait_to_ff       <= WAIT_TIMEOUT_RST;
         speed_ok_ff      <= 1'b1;
         phase_ff         <= PH_INIT;
         init_step_ff     <= 3'd0;
         query_sent_ff    <= 1'b0;
         support_known_ff <= 1'b0;
         speed_sched_ff   <= 1'b0;
         sched_len_ff     <= '0;
         sched_slot_ff    <= '0;
         awaited_ff       <= 8'd0;
         last_act_ff      <= 32'd0;
         last_tick_ff     <= 32'd0;
      end else begin
         step_to_ff       <= step_to_in;
         poll_iv_ff       <= poll_iv_in;
         wait_to_ff       <= wait_to_in;
         speed_ok_ff      <= speed_ok_in;
         phase_ff         <= phase_in;
         init_step_ff     <= init_step_in;
         query_sent_ff    <= query_sent_in;
         support_known_ff <= support_known_in;
         speed_sched_ff   <= speed_sched_in;
         sched_len_ff     <= sched_len_in;
         sched_slot_ff    <= sched_slot_in;
         awaited_ff       <= awaited_in;
         last_act_ff      <= last_act_in;
         last_tick_ff     <= last_tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item;
      end
      elapsed_ff     <= elapsed_in;
      build_speed_ff <= build_speed_in;
      round_ff       <= round_in;
      sub_ff         <= sub_in;
      kind_ff        <= kind_in;
      cmd_ff         <= cmd_in;
      req_pid_ff     <= req_pid_in;
      claimed_ff     <= claimed_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sched_mem[sched_len_ff[SW-1:0]] <= wr_pid;
      end
   end

   always_ff @(posedge clock) begin
      if (exec && (cw.uop == UOP_READ_SLOT)) begin
         rd_data_ff <= sched_mem[sched_slot_ff];
      end
   end

endmodule

/* rtl/core/obdps_sequencer.sv */
// ----------------------------------------------------------------------------
// OBD poll scheduler sequencer
// Input handshake, micro-program counter with branches, and result register.
// ----------------------------------------------------------------------------
module obdps_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  obdps_pkg::req_type       req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output obdps_pkg::rsp_type       rsp_data,
   input  obdps_pkg::ctrl_word_type cw,
   input  obdps_pkg::status_type    status,
   input  obdps_pkg::rsp_type       result,
   output obdps_pkg::upc_type       upc,
   output logic                     accept,
   output logic                     exec
);
   import obdps_pkg::*;

   logic    running_ff, running_in;
   upc_type upc_ff, upc_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   upc_type entry;
   upc_type next_upc;
   logic    taken;
   logic    out_free;
   logic    finish;

   assign req_stall = running_ff;
   assign accept    = req_valid && !running_ff;
   assign exec      = running_ff;
   assign upc       = upc_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = running_ff && (cw.uop == UOP_FINISH) && out_free;

   always_comb begin
      case (req_data.opcode)
         OP_START:  entry = UA_START;
         OP_TICK:   entry = UA_TICK;
         OP_RESP:   entry = UA_RESP;
         OP_BITMAP: entry = UA_BITMAP;
         default:   entry = UA_FINISH;
      endcase
   end

   always_comb begin
      case (cw.cond)
         COND_ALWAYS:     taken = 1'b1;
         COND_BUILD_MORE: taken = status.build_more;
         COND_REBUILD:    taken = status.rebuild;
         COND_NEW_MAP:    taken = status.new_map;
         default:         taken = 1'b1;
      endcase
      if (cw.cond == COND_DISPATCH) begin
         next_upc = cw.target_t + UPC_W'(status.phase);
      end else if (taken) begin
         next_upc = cw.target_t;
      end else begin
         next_upc = cw.target_f;
      end
   end

   always_comb begin
      running_in   = running_ff;
      upc_in       = upc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         running_in = 1'b1;
         upc_in     = entry;
      end else if (running_ff) begin
         if (cw.uop == UOP_FINISH) begin
            // The result waits here until the output register is free.
            if (finish) begin
               running_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
            end
         end else begin
            upc_in = next_upc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         upc_ff       <= UA_FINISH;
         rsp_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
